### rtl/ihde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihde_pkg
// Types shared by the image header dimension extractor modules.
// ----------------------------------------------------------------------------
package ihde_pkg;

	localparam int unsigned DimW = 31;

	// One input byte with its side information.
	typedef struct packed {
		logic [7:0] data_byte;
		logic [1:0] image_format;
		logic       last_byte;
	} ihde_item_t;

	// One result per file.
	typedef struct packed {
		logic            found;
		logic [DimW-1:0] image_width;
		logic [DimW-1:0] image_height;
	} ihde_result_t;

endpackage

### rtl/image_header_dimension_extractor_core.sv
`timescale 1ns / 1ps
// A result shows on m_tvalid once its last byte is loaded into the result register.
// One byte is taken per cycle, unless a last byte waits on a full result register.
// A last byte waits in the input register only while the result register is full.
// Reset (arst_n low, asynchronous) empties both registers and returns the parser to
// the start of a file.
// ----------------------------------------------------------------------------
// image_header_dimension_extractor_core
// Streams the bytes of one image file and returns its width and height.
// ----------------------------------------------------------------------------
module image_header_dimension_extractor_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic [1:0]  s_tuser,  // [1:0] image_format
	input  logic        s_tlast,  // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // [30:0] image_width, [61:31] image_height, [63:62] zero
	output logic        m_tuser   // [0] found
);

	ihde_pkg::ihde_item_t   in_item;
	ihde_pkg::ihde_item_t   item;
	ihde_pkg::ihde_result_t parse_result;
	ihde_pkg::ihde_result_t out_result;
	logic                   item_valid;
	logic                   item_take;
	logic                   slot_free;

	assign in_item.data_byte    = s_tdata;
	assign in_item.image_format = s_tuser;
	assign in_item.last_byte    = s_tlast;

	// Bytes other than the last never need the result register.
	assign item_take = item_valid && (!item.last_byte || slot_free);

	ihde_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_item    (in_item),
		.item_valid (item_valid),
		.item_take  (item_take),
		.item       (item)
	);

	ihde_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (item_take),
		.item   (item),
		.result (parse_result)
	);

	ihde_out_stage u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (item_take && item.last_byte),
		.load_result (parse_result),
		.slot_free   (slot_free),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_result  (out_result)
	);

	assign m_tdata = {2'b00, out_result.image_height, out_result.image_width};
	assign m_tuser = out_result.found;

endmodule

### rtl/ihde_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihde_in_stage
// Input register: holds one accepted byte until the parser consumes it.
// ----------------------------------------------------------------------------
module ihde_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ihde_pkg::ihde_item_t in_item,
	output logic               item_valid,
	input  logic               item_take,
	output ihde_pkg::ihde_item_t item
);

	logic                 valid_s1;
	ihde_pkg::ihde_item_t item_s1;

	// A new transaction may enter in the same cycle the held one is consumed.
	assign in_ready   = !valid_s1 || item_take;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

### rtl/ihde_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihde_parser
// Per-byte header parser for PNG and JPEG dimension fields.
// ----------------------------------------------------------------------------
module ihde_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  ihde_pkg::ihde_item_t   item,
	output ihde_pkg::ihde_result_t result
);

	localparam logic [3:0] PH_START  = 4'd0;
	localparam logic [3:0] PH_PNG    = 4'd1;
	localparam logic [3:0] PH_J_LEAD = 4'd2;
	localparam logic [3:0] PH_J_SCAN = 4'd3;
	localparam logic [3:0] PH_J_MARK = 4'd4;
	localparam logic [3:0] PH_J_LENH = 4'd5;
	localparam logic [3:0] PH_J_LENL = 4'd6;
	localparam logic [3:0] PH_J_SKIP = 4'd7;
	localparam logic [3:0] PH_J_SOF  = 4'd8;
	localparam logic [3:0] PH_J_TAIL = 4'd9;
	localparam logic [3:0] PH_DONE   = 4'd10;

	localparam logic [1:0] V_UNDECIDED = 2'd0;
	localparam logic [1:0] V_FAILED    = 2'd1;
	localparam logic [1:0] V_FOUND     = 2'd2;

	localparam logic [1:0] FMT_PNG  = 2'd0;
	localparam logic [1:0] FMT_JPEG = 2'd1;

	localparam logic [7:0] TAG_I = 8'h49;
	localparam logic [7:0] TAG_H = 8'h48;
	localparam logic [7:0] TAG_D = 8'h44;
	localparam logic [7:0] TAG_R = 8'h52;

	localparam logic [7:0] MK_PREFIX = 8'hFF;
	localparam logic [7:0] MK_SOF_LO = 8'hC0;
	localparam logic [7:0] MK_SOF_HI = 8'hCF;
	localparam logic [7:0] MK_DHT    = 8'hC4;
	localparam logic [7:0] MK_JPG    = 8'hC8;
	localparam logic [7:0] MK_DAC    = 8'hCC;
	localparam logic [7:0] MK_SOI    = 8'hD8;
	localparam logic [7:0] MK_TEM    = 8'h01;
	localparam logic [7:0] MK_RST_LO = 8'hD0;
	localparam logic [7:0] MK_RST_HI = 8'hD7;

	localparam logic [4:0] PNG_LAST_POS = 5'd23;

	logic [3:0]  phase_q,   phase_d;
	logic [4:0]  pos_q,     pos_d;
	logic [15:0] skip_q,    skip_d;
	logic [7:0]  lenh_q,    lenh_d;
	logic [1:0]  fmt_q,     fmt_d;
	logic [31:0] wacc_q,    wacc_d;
	logic [31:0] hacc_q,    hacc_d;
	logic [1:0]  verdict_q, verdict_d;

	always_comb begin
		logic [7:0]  b;
		logic [7:0]  tag_byte;
		logic [15:0] seg_len;
		logic        ok;
		b         = item.data_byte;
		tag_byte  = TAG_I;
		seg_len   = 16'd0;
		ok        = 1'b0;
		phase_d   = phase_q;
		pos_d     = pos_q;
		skip_d    = skip_q;
		lenh_d    = lenh_q;
		fmt_d     = fmt_q;
		wacc_d    = wacc_q;
		hacc_d    = hacc_q;
		verdict_d = verdict_q;

		// The first byte of a file starts from cleared state and picks the format.
		if (phase_q == PH_START) begin
			pos_d     = 5'd0;
			skip_d    = 16'd0;
			lenh_d    = 8'd0;
			wacc_d    = 32'd0;
			hacc_d    = 32'd0;
			verdict_d = V_UNDECIDED;
			fmt_d     = item.image_format;
			case (item.image_format)
				FMT_PNG:  phase_d = PH_PNG;
				FMT_JPEG: phase_d = PH_J_LEAD;
				default: begin
					phase_d   = PH_DONE;
					verdict_d = V_FAILED;
				end
			endcase
		end

		unique case (phase_d)
			PH_PNG: begin
				case (pos_d[1:0])
					2'd0:    tag_byte = TAG_I;
					2'd1:    tag_byte = TAG_H;
					2'd2:    tag_byte = TAG_D;
					default: tag_byte = TAG_R;
				endcase
				if (pos_d >= 5'd12 && pos_d <= 5'd15 && b != tag_byte) begin
					phase_d   = PH_DONE;
					verdict_d = V_FAILED;
				end else begin
					if (pos_d >= 5'd16 && pos_d <= 5'd19) begin
						wacc_d = {wacc_d[23:0], b};
					end else if (pos_d >= 5'd20 && pos_d <= 5'd23) begin
						hacc_d = {hacc_d[23:0], b};
					end
					if (pos_d == PNG_LAST_POS) begin
						ok = (wacc_d != 32'd0) && !wacc_d[31] &&
						     (hacc_d != 32'd0) && !hacc_d[31];
						phase_d   = PH_DONE;
						verdict_d = ok ? V_FOUND : V_FAILED;
					end else begin
						pos_d = pos_d + 5'd1;
					end
				end
			end
			PH_J_LEAD: begin
				if (pos_d >= 5'd1) begin
					phase_d = PH_J_SCAN;
				end
				pos_d = pos_d + 5'd1;
			end
			PH_J_SCAN: begin
				if (b == MK_PREFIX) begin
					phase_d = PH_J_MARK;
				end
			end
			PH_J_MARK: begin
				if (b >= MK_SOF_LO && b <= MK_SOF_HI && b != MK_DHT && b != MK_JPG &&
				    b != MK_DAC) begin
					pos_d   = 5'd0;
					wacc_d  = 32'd0;
					hacc_d  = 32'd0;
					phase_d = PH_J_SOF;
				end else if (b == MK_SOI || b == MK_TEM ||
				             (b >= MK_RST_LO && b <= MK_RST_HI)) begin
					phase_d = PH_J_SCAN;
				end else begin
					phase_d = PH_J_LENH;
				end
			end
			PH_J_LENH: begin
				lenh_d  = b;
				phase_d = PH_J_LENL;
			end
			PH_J_LENL: begin
				seg_len = {lenh_d, b};
				if (seg_len < 16'd2) begin
					phase_d   = PH_DONE;
					verdict_d = V_FAILED;
				end else begin
					skip_d  = seg_len - 16'd2;
					phase_d = (skip_d == 16'd0) ? PH_J_SCAN : PH_J_SKIP;
				end
			end
			PH_J_SKIP: begin
				skip_d = skip_d - 16'd1;
				if (skip_d == 16'd0) begin
					phase_d = PH_J_SCAN;
				end
			end
			PH_J_SOF: begin
				// Frame header: length, precision, height, width.
				if (pos_d == 5'd3 || pos_d == 5'd4) begin
					hacc_d = {16'd0, hacc_d[7:0], b};
				end else if (pos_d == 5'd5 || pos_d == 5'd6) begin
					wacc_d = {16'd0, wacc_d[7:0], b};
				end
				if (pos_d >= 5'd6) begin
					phase_d = PH_J_TAIL;
				end
				pos_d = pos_d + 5'd1;
			end
			PH_J_TAIL: begin
				phase_d   = PH_DONE;
				verdict_d = (wacc_d != 32'd0 && hacc_d != 32'd0) ? V_FOUND : V_FAILED;
			end
			PH_DONE: begin
			end
			default: begin
				phase_d   = PH_DONE;
				verdict_d = V_FAILED;
			end
		endcase
	end

	always_comb begin
		result.found        = (verdict_d == V_FOUND);
		result.image_width  = result.found ? wacc_d[ihde_pkg::DimW-1:0] : '0;
		result.image_height = result.found ? hacc_d[ihde_pkg::DimW-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START;
			pos_q     <= 5'd0;
			skip_q    <= 16'd0;
			lenh_q    <= 8'd0;
			fmt_q     <= 2'd0;
			wacc_q    <= 32'd0;
			hacc_q    <= 32'd0;
			verdict_q <= V_UNDECIDED;
		end else if (step) begin
			if (item.last_byte) begin
				phase_q   <= PH_START;
				pos_q     <= 5'd0;
				skip_q    <= 16'd0;
				lenh_q    <= 8'd0;
				fmt_q     <= 2'd0;
				wacc_q    <= 32'd0;
				hacc_q    <= 32'd0;
				verdict_q <= V_UNDECIDED;
			end else begin
				phase_q   <= phase_d;
				pos_q     <= pos_d;
				skip_q    <= skip_d;
				lenh_q    <= lenh_d;
				fmt_q     <= fmt_d;
				wacc_q    <= wacc_d;
				hacc_q    <= hacc_d;
				verdict_q <= verdict_d;
			end
		end
	end

`ifndef SYNTHESIS
	a_found_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(step && result.found) |-> (result.image_width != '0 && result.image_height != '0))
		else $error("found reported with a zero dimension");

	a_restart_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item.last_byte) |=> (phase_q == PH_START && verdict_q == V_UNDECIDED))
		else $error("parser did not return to start after the last byte");

	a_png_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PNG) |-> (pos_q <= PNG_LAST_POS))
		else $error("PNG byte position ran past the header");

	a_jpeg_dim_16bit: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_J_SOF || phase_q == PH_J_TAIL) |->
		(wacc_q[31:16] == 16'd0 && hacc_q[31:16] == 16'd0))
		else $error("JPEG dimension accumulator exceeded 16 bits");
`endif

endmodule

### rtl/ihde_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihde_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module ihde_out_stage (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  ihde_pkg::ihde_result_t load_result,
	output logic                   slot_free,
	output logic                   out_valid,
	input  logic                   out_ready,
	output ihde_pkg::ihde_result_t out_result
);

	logic                   valid_q;
	ihde_pkg::ihde_result_t result_q;

	assign slot_free  = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign out_result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && load) begin
			result_q <= load_result;
		end
	end

endmodule
